>>> rtl/core/ttb_pkg.sv
`timescale 1ns / 1ps

package ttb_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AccW  = 65;
  localparam int unsigned NormW = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_CHK,
    S_DIVW,
    S_OUT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic div_start;
    logic sel_second;
  } ctrl_t;

  function automatic logic signed [DataW-1:0] sat_sub(input logic signed [DataW-1:0] a,
                                                      input logic signed [DataW-1:0] b);
    logic signed [DataW:0] d;
    d = {a[DataW-1], a} - {b[DataW-1], b};
    if (d[DataW] != d[DataW-1]) begin
      return d[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end
    return d[DataW-1:0];
  endfunction

endpackage

>>> rtl/core/ttb_mul.sv
`timescale 1ns / 1ps

module ttb_mul (
  input  logic                             clk_i,
  input  logic signed [ttb_pkg::DataW-1:0] a_i,
  input  logic signed [ttb_pkg::DataW-1:0] b_i,
  output logic signed [2*ttb_pkg::DataW-1:0] p_o
);

  logic signed [2*ttb_pkg::DataW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/ttb_div.sv
`timescale 1ns / 1ps

module ttb_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ttb_pkg::AccW-1:0]  num_i,
  input  logic signed [ttb_pkg::AccW-1:0]  den_i,
  output logic                             done_o,
  output logic signed [ttb_pkg::DataW-1:0] quot_o
);

  localparam int MagW  = ttb_pkg::AccW - 1;
  localparam int NBits = MagW + FRAC_BITS;
  localparam int CntW  = $clog2(NBits + 1);
  localparam int QW    = ttb_pkg::DataW;

  logic            busy_q, done_q, ovf_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [NBits-1:0] sh_q;
  logic [MagW:0]   rem_q, rem_sh, rem_nx;
  logic [MagW-1:0] den_q;
  logic [QW-1:0]   quo_q;
  logic            ge;
  logic [ttb_pkg::AccW-1:0] num_mag, den_mag;

  assign num_mag = num_i[ttb_pkg::AccW-1] ? -num_i : num_i;
  assign den_mag = den_i[ttb_pkg::AccW-1] ? -den_i : den_i;
  assign rem_sh  = {rem_q[MagW-1:0], sh_q[NBits-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_nx  = ge ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q & ~start_i & (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= {num_mag[MagW-1:0], {FRAC_BITS{1'b0}}};
      den_q <= den_mag[MagW-1:0];
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_i[ttb_pkg::AccW-1] ^ den_i[ttb_pkg::AccW-1];
    end else if (busy_q) begin
      sh_q  <= {sh_q[NBits-2:0], 1'b0};
      rem_q <= rem_nx;
      quo_q <= {quo_q[QW-2:0], ge};
      ovf_q <= ovf_q | quo_q[QW-1];
    end
  end

  always_comb begin
    if (ovf_q || quo_q[QW-1]) begin
      quot_o = neg_q ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      quot_o = neg_q ? -quo_q : quo_q;
    end
  end

  assign done_o = done_q;

endmodule

>>> rtl/core/triangle_tangent_builder_core.sv
`timescale 1ns / 1ps

// The first two corners of a triangle are stored and give no item.
// The third corner runs one shared 32x32 multiplier and one bit-serial divider;
// a degenerate triangle (zero determinant) skips the divides.
// Each of the six divides runs 64 + FRAC_BITS steps.
// Three result items follow, one per cycle while the output is ready.
// Reset is asynchronous, active low, and clears the corner count and uv_source.

module triangle_tangent_builder_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [31:0] tex_u_i,
  input  logic signed [31:0] tex_v_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  corner_o,
  output logic signed [31:0] out_u_o,
  output logic signed [31:0] out_v_o,
  output logic signed [31:0] tangent_x_o,
  output logic signed [31:0] tangent_y_o,
  output logic signed [31:0] tangent_z_o,
  output logic signed [31:0] bitangent_x_o,
  output logic signed [31:0] bitangent_y_o,
  output logic signed [31:0] bitangent_z_o,
  output logic        degenerate_o,
  output logic        last_o
);

  localparam int DW = ttb_pkg::DataW;
  localparam int AW = ttb_pkg::AccW;

  ttb_pkg::state_e state_q, state_d;
  ttb_pkg::ctrl_t  ctrl;

  logic       uv_src_q;
  logic [1:0] cnt_q;
  logic [1:0] ocorner_q;
  logic [2:0] qi_q;
  logic [1:0] jsel;
  logic       degen_q;

  logic signed [DW-1:0] px_q [3];
  logic signed [DW-1:0] py_q [3];
  logic signed [DW-1:0] pz_q [3];
  logic signed [DW-1:0] cu_q [3];
  logic signed [DW-1:0] cv_q [3];
  logic signed [DW-1:0] dp1_q [3];
  logic signed [DW-1:0] dp2_q [3];
  logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [DW-1:0] res_q [6];
  logic signed [AW-1:0] acc_q, num_q, det_q, num_d;

  logic signed [DW-1:0]   op_a, op_b;
  logic signed [2*DW-1:0] prod;
  logic signed [DW-1:0]   quot;
  logic                   div_done;

  logic [16:0] anx, any, anz;
  logic signed [DW-1:0] hx, hy, hz, cu_in, cv_in;
  logic in_acc, out_acc;

  assign in_acc  = in_valid_i & ctrl.in_ready;
  assign out_acc = ctrl.out_valid & out_ready_i;

  assign anx = normal_x_i[15] ? 17'(-{normal_x_i[15], normal_x_i}) : {1'b0, normal_x_i};
  assign any = normal_y_i[15] ? 17'(-{normal_y_i[15], normal_y_i}) : {1'b0, normal_y_i};
  assign anz = normal_z_i[15] ? 17'(-{normal_z_i[15], normal_z_i}) : {1'b0, normal_z_i};
  assign hx  = pos_x_i >>> 1;
  assign hy  = pos_y_i >>> 1;
  assign hz  = pos_z_i >>> 1;

  always_comb begin
    cu_in = tex_u_i;
    cv_in = tex_v_i;
    if (uv_src_q) begin
      if (anx > any) begin
        cu_in = (anz > anx) ? hx : hz;
        cv_in = hy;
      end else begin
        cu_in = hx;
        cv_in = (anz > any) ? hy : hz;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttb_pkg::S_IDLE:  if (in_acc && cnt_q == 2'd2) state_d = ttb_pkg::S_DELTA;
      ttb_pkg::S_DELTA: state_d = ttb_pkg::S_MUL0;
      ttb_pkg::S_MUL0:  state_d = ttb_pkg::S_MUL1;
      ttb_pkg::S_MUL1:  state_d = ttb_pkg::S_MUL2;
      ttb_pkg::S_MUL2:  state_d = ttb_pkg::S_CHK;
      ttb_pkg::S_CHK: begin
        if (qi_q != 3'd0) state_d = ttb_pkg::S_DIVW;
        else if (num_q == '0) state_d = ttb_pkg::S_OUT;
        else state_d = ttb_pkg::S_MUL0;
      end
      ttb_pkg::S_DIVW: begin
        if (div_done) state_d = (qi_q == 3'd6) ? ttb_pkg::S_OUT : ttb_pkg::S_MUL0;
      end
      ttb_pkg::S_OUT: if (out_acc && ocorner_q == 2'd2) state_d = ttb_pkg::S_IDLE;
      default: state_d = ttb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.in_ready   = (state_q == ttb_pkg::S_IDLE);
    ctrl.out_valid  = (state_q == ttb_pkg::S_OUT);
    ctrl.div_start  = (state_q == ttb_pkg::S_CHK) && (qi_q != 3'd0);
    ctrl.sel_second = (state_q == ttb_pkg::S_MUL1);
  end

  assign jsel = (qi_q <= 3'd3) ? 2'(qi_q - 3'd1) : 2'(qi_q - 3'd4);

  always_comb begin
    if (qi_q == 3'd0) begin
      op_a = ctrl.sel_second ? du2_q : du1_q;
      op_b = ctrl.sel_second ? dv1_q : dv2_q;
    end else if (qi_q <= 3'd3) begin
      op_a = ctrl.sel_second ? dp2_q[jsel] : dp1_q[jsel];
      op_b = ctrl.sel_second ? dv1_q : dv2_q;
    end else begin
      op_a = ctrl.sel_second ? dp1_q[jsel] : dp2_q[jsel];
      op_b = ctrl.sel_second ? du2_q : du1_q;
    end
  end

  ttb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  ttb_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .num_i   (num_q),
    .den_i   (det_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign num_d = acc_q - {prod[2*DW-1], prod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttb_pkg::S_IDLE;
      uv_src_q  <= 1'b0;
      cnt_q     <= 2'd0;
      ocorner_q <= 2'd0;
      qi_q      <= 3'd0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) uv_src_q <= cfg_wdata_i;
      if (in_acc) cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
      if (state_q == ttb_pkg::S_DELTA) begin
        qi_q      <= 3'd0;
        ocorner_q <= 2'd0;
      end
      if (state_q == ttb_pkg::S_CHK && qi_q == 3'd0) qi_q <= 3'd1;
      if (state_q == ttb_pkg::S_DIVW && div_done) qi_q <= qi_q + 3'd1;
      if (out_acc) ocorner_q <= ocorner_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q[cnt_q] <= pos_x_i;
      py_q[cnt_q] <= pos_y_i;
      pz_q[cnt_q] <= pos_z_i;
      cu_q[cnt_q] <= cu_in;
      cv_q[cnt_q] <= cv_in;
    end
    if (state_q == ttb_pkg::S_DELTA) begin
      dp1_q[0] <= ttb_pkg::sat_sub(px_q[1], px_q[0]);
      dp1_q[1] <= ttb_pkg::sat_sub(py_q[1], py_q[0]);
      dp1_q[2] <= ttb_pkg::sat_sub(pz_q[1], pz_q[0]);
      dp2_q[0] <= ttb_pkg::sat_sub(px_q[2], px_q[0]);
      dp2_q[1] <= ttb_pkg::sat_sub(py_q[2], py_q[0]);
      dp2_q[2] <= ttb_pkg::sat_sub(pz_q[2], pz_q[0]);
      du1_q    <= ttb_pkg::sat_sub(cu_q[1], cu_q[0]);
      dv1_q    <= ttb_pkg::sat_sub(cv_q[1], cv_q[0]);
      du2_q    <= ttb_pkg::sat_sub(cu_q[2], cu_q[0]);
      dv2_q    <= ttb_pkg::sat_sub(cv_q[2], cv_q[0]);
    end
    if (state_q == ttb_pkg::S_MUL1) acc_q <= {prod[2*DW-1], prod};
    if (state_q == ttb_pkg::S_MUL2) num_q <= num_d;
    if (state_q == ttb_pkg::S_CHK && qi_q == 3'd0) begin
      det_q   <= num_q;
      degen_q <= (num_q == '0);
      for (int i = 0; i < 6; i++) res_q[i] <= '0;
    end
    if (state_q == ttb_pkg::S_DIVW && div_done) res_q[3'(qi_q - 3'd1)] <= quot;
  end

  assign in_ready_o    = ctrl.in_ready;
  assign out_valid_o   = ctrl.out_valid;
  assign corner_o      = ocorner_q;
  assign out_u_o       = cu_q[ocorner_q];
  assign out_v_o       = cv_q[ocorner_q];
  assign tangent_x_o   = res_q[0];
  assign tangent_y_o   = res_q[1];
  assign tangent_z_o   = res_q[2];
  assign bitangent_x_o = res_q[3];
  assign bitangent_y_o = res_q[4];
  assign bitangent_z_o = res_q[5];
  assign degenerate_o  = degen_q;
  assign last_o        = (ocorner_q == 2'd2);

endmodule

>>> verif/tb_triangle_tangent_builder_core.sv
`timescale 1ns / 1ps

module tb_triangle_tangent_builder_core;

  localparam int FracBits   = 16;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 700;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic signed [31:0] tu, tv;
  } vtx_item_t;

  typedef struct {
    logic [1:0]         corner;
    logic signed [31:0] u, v;
    logic signed [31:0] tx, ty, tz;
    logic signed [31:0] bx, by, bz;
    logic               degen;
    logic               last;
  } corner_res_t;

  class tangent_scoreboard;
    logic               planar;
    int                 held;
    vtx_item_t          corners [2];
    logic signed [31:0] coords [2][2];
    corner_res_t        expected_q [$];
    int                 errors;
    int                 triangles;
    int                 degenerates;

    function new();
      planar = 1'b0;
      held = 0;
      errors = 0;
      triangles = 0;
      degenerates = 0;
    endfunction

    function automatic logic signed [31:0] sat_diff(logic signed [31:0] a,
                                                   logic signed [31:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d > 64'sd2147483647) return 32'sh7fffffff;
      if (d < -64'sd2147483648) return 32'sh80000000;
      return d[31:0];
    endfunction

    function automatic logic signed [31:0] scaled_div(logic signed [65:0] num,
                                                     logic signed [65:0] den);
      logic        neg;
      logic [95:0] nn, dd, qq;
      neg = num[65] ^ den[65];
      nn = 96'(num[65] ? -num : num) << FracBits;
      dd = 96'(den[65] ? -den : den);
      qq = nn / dd;
      if (qq > 96'h7fffffff) return neg ? 32'sh80000000 : 32'sh7fffffff;
      return neg ? -$signed(qq[31:0]) : $signed(qq[31:0]);
    endfunction

    function automatic void note_vertex(vtx_item_t vx);
      int                 ax, ay, az;
      logic signed [31:0] cu, cv, hx, hy, hz;
      logic signed [31:0] dp1 [3], dp2 [3], pa [3], pb [3], pc [3], uu [3], vv [3];
      logic signed [31:0] du1, dv1, du2, dv2;
      logic signed [65:0] e1, e2, f1, f2, det, g1, g2, nt, nb;
      logic signed [31:0] tv [3], bv [3];
      corner_res_t        r;
      ax = vx.nx < 0 ? -int'(vx.nx) : int'(vx.nx);
      ay = vx.ny < 0 ? -int'(vx.ny) : int'(vx.ny);
      az = vx.nz < 0 ? -int'(vx.nz) : int'(vx.nz);
      hx = vx.px >>> 1;
      hy = vx.py >>> 1;
      hz = vx.pz >>> 1;
      if (!planar) begin
        cu = vx.tu;
        cv = vx.tv;
      end else if (ax > ay) begin
        if (az > ax) begin
          cu = hx; cv = hy;
        end else begin
          cu = hz; cv = hy;
        end
      end else begin
        if (az > ay) begin
          cu = hx; cv = hy;
        end else begin
          cu = hx; cv = hz;
        end
      end
      if (held < 2) begin
        corners[held] = vx;
        coords[held][0] = cu;
        coords[held][1] = cv;
        held++;
        return;
      end
      held = 0;
      triangles++;
      pa = '{corners[0].px, corners[0].py, corners[0].pz};
      pb = '{corners[1].px, corners[1].py, corners[1].pz};
      pc = '{vx.px, vx.py, vx.pz};
      uu = '{coords[0][0], coords[1][0], cu};
      vv = '{coords[0][1], coords[1][1], cv};
      for (int j = 0; j < 3; j++) begin
        dp1[j] = sat_diff(pb[j], pa[j]);
        dp2[j] = sat_diff(pc[j], pa[j]);
      end
      du1 = sat_diff(uu[1], uu[0]);
      dv1 = sat_diff(vv[1], vv[0]);
      du2 = sat_diff(uu[2], uu[0]);
      dv2 = sat_diff(vv[2], vv[0]);
      e1 = du1; e2 = du2; f1 = dv1; f2 = dv2;
      det = e1 * f2 - e2 * f1;
      for (int j = 0; j < 3; j++) begin
        g1 = dp1[j];
        g2 = dp2[j];
        nt = g1 * f2 - g2 * f1;
        nb = g2 * e1 - g1 * e2;
        tv[j] = (det == 0) ? '0 : scaled_div(nt, det);
        bv[j] = (det == 0) ? '0 : scaled_div(nb, det);
      end
      if (det == 0) degenerates++;
      for (int k = 0; k < 3; k++) begin
        r.corner = 2'(k);
        r.u = uu[k];
        r.v = vv[k];
        r.tx = tv[0]; r.ty = tv[1]; r.tz = tv[2];
        r.bx = bv[0]; r.by = bv[1]; r.bz = bv[2];
        r.degen = (det == 0);
        r.last = (k == 2);
        expected_q.push_back(r);
      end
    endfunction

    function automatic void compare(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        $error("%s: expected %h, got %h", name, exp, got);
        errors++;
      end
    endfunction

    function automatic void check_result(corner_res_t got);
      corner_res_t e;
      if (expected_q.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("corner", 32'(e.corner), 32'(got.corner));
      compare("out_u", e.u, got.u);
      compare("out_v", e.v, got.v);
      compare("tangent_x", e.tx, got.tx);
      compare("tangent_y", e.ty, got.ty);
      compare("tangent_z", e.tz, got.tz);
      compare("bitangent_x", e.bx, got.bx);
      compare("bitangent_y", e.by, got.by);
      compare("bitangent_z", e.bz, got.bz);
      compare("degenerate", 32'(e.degen), 32'(got.degen));
      compare("last", 32'(e.last), 32'(got.last));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic signed [31:0] tex_u_i = '0, tex_v_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] corner_o;
  logic signed [31:0] out_u_o, out_v_o;
  logic signed [31:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic signed [31:0] bitangent_x_o, bitangent_y_o, bitangent_z_o;
  logic degenerate_o, last_o;

  tangent_scoreboard tangents = new();
  int cycles = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int burst_left = 0;

  always #1 clk_i = ~clk_i;

  triangle_tangent_builder_core #(.FRAC_BITS(FracBits)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .pos_x_i, .pos_y_i, .pos_z_i, .normal_x_i, .normal_y_i, .normal_z_i,
    .tex_u_i, .tex_v_i, .out_valid_o, .out_ready_i, .corner_o, .out_u_o, .out_v_o,
    .tangent_x_o, .tangent_y_o, .tangent_z_o,
    .bitangent_x_o, .bitangent_y_o, .bitangent_z_o, .degenerate_o, .last_o
  );

  always @(posedge clk_i) begin
    corner_res_t got;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      tangents.note_vertex('{pos_x_i, pos_y_i, pos_z_i, normal_x_i, normal_y_i,
                             normal_z_i, tex_u_i, tex_v_i});
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{corner_o, out_u_o, out_v_o, tangent_x_o, tangent_y_o, tangent_z_o,
              bitangent_x_o, bitangent_y_o, bitangent_z_o, degenerate_o, last_o};
      tangents.check_result(got);
    end
  end

  initial begin
    int hold = 0, style = 0, span = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_done < hold_reqs) begin
        hold_done++;
        hold = HoldCycles;
      end
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
      end
      span--;
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= (cycles % 5) < 2;
          default: out_ready_i <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  function automatic logic signed [31:0] rand_word(bit wide);
    if (wide) return $urandom;
    return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
  endfunction

  function automatic vtx_item_t rand_vertex(bit wide);
    vtx_item_t vx;
    vx.px = rand_word(wide);
    vx.py = rand_word(wide);
    vx.pz = rand_word(wide);
    vx.nx = 16'($urandom);
    vx.ny = ($urandom_range(0, 7) == 0) ? vx.nx : 16'($urandom);
    vx.nz = ($urandom_range(0, 7) == 0) ? -vx.ny : 16'($urandom);
    vx.tu = rand_word(wide);
    vx.tv = rand_word(wide);
    return vx;
  endfunction

  task automatic send_vertex(vtx_item_t vx);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    pos_x_i <= vx.px; pos_y_i <= vx.py; pos_z_i <= vx.pz;
    normal_x_i <= vx.nx; normal_y_i <= vx.ny; normal_z_i <= vx.nz;
    tex_u_i <= vx.tu; tex_v_i <= vx.tv;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_mode(logic mode);
    in_valid_i <= 1'b0;
    while (tangents.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tangents.planar = mode;
  endtask

  task automatic send_directed();
    logic signed [31:0] mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_vertex('{0, 0, 0, 16'sh4000, 0, 0, 0, 0});
    send_vertex('{32'sh10000, 0, 0, 16'sh4000, 0, 0, 32'sh10000, 0});
    send_vertex('{0, 32'sh10000, 0, 16'sh4000, 0, 0, 0, 32'sh10000});
    send_vertex('{1, 2, 3, 0, 0, 0, 5, 7});
    send_vertex('{4, 5, 6, 0, 0, 0, 5, 7});
    send_vertex('{7, 8, 9, 0, 0, 0, 5, 7});
    send_vertex('{mn, mn, mn, 16'sh8000, 16'sh8000, 16'sh8000, mn, mn});
    send_vertex('{mx, mx, mx, 16'sh7fff, 16'sh7fff, 16'sh7fff, mx, mn});
    send_vertex('{mn, mx, 0, 16'sh8000, 16'sh7fff, 0, mn, mx});
    send_vertex('{0, 0, 0, 0, 0, 0, 0, 0});
    send_vertex('{mx, mn, mx, 0, 0, 0, 1, 0});
    send_vertex('{mn, mx, mn, 0, 0, 0, 0, 1});
    send_vertex('{-1, -3, 5, 0, 0, 0, 0, 0});
    send_vertex('{mx, 0, -7, 0, 0, 0, mx, 1});
    send_vertex('{mn, 1, 9, 0, 0, 0, 1, mx});
  endtask

  task automatic send_planar_directed();
    send_vertex('{-3, -5, -7, 16'sh0100, 16'sh0010, 16'sh1000, 0, 0});
    send_vertex('{32'sh20001, 5, -9, 16'sh1000, 16'sh0010, 16'sh0100, 0, 0});
    send_vertex('{11, 32'sh40003, 13, 16'sh0010, 16'sh1000, 16'sh0100, 0, 0});
    send_vertex('{1, 2, 3, 16'sh0800, 16'sh0800, 16'sh0800, 0, 0});
    send_vertex('{32'sh7fffffff, 32'sh80000000, 5, 16'sh8000, 16'sh7fff, 16'sh0, 0, 0});
    send_vertex('{32'sh80000000, 7, 32'sh7fffffff, 16'sh0, 16'sh8000, 16'sh8000, 0, 0});
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      send_vertex(rand_vertex($urandom_range(0, 5) == 0));
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_mode(1'b0);
    send_directed();
    set_mode(1'b1);
    send_planar_directed();
    hold_reqs++;
    run_random(36);
    set_mode(1'b0);
    run_random(45);
    set_mode(1'b1);
    run_random(30);
    set_mode(1'b0);
    hold_reqs++;
    run_random(36);
    in_valid_i <= 1'b0;
    while (tangents.expected_q.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    $display("Covered %0d triangles (%0d degenerate) across supplied and planar modes.",
             tangents.triangles, tangents.degenerates);
    $display("Receiver held off for long stretches twice while vertices kept coming.");
    if (tangents.errors == 0 && tangents.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
